/* rtl/core/lpbf_pkg.sv */
// Shared types and constants of the longest-path core.
`default_nettype none

package lpbf_pkg;

   localparam int VTX_W    = 6;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;
   localparam int GAIN_W   = 31;
   localparam int CFG_W    = 7;

   localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 7'd64;

   localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                       operation;
      logic [VTX_W-1:0]           edge_from;
      logic [VTX_W-1:0]           edge_to;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic [VTX_W-1:0]           source_vertex;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]  result_source;
      logic [GAIN_W-1:0] best_gain;
      logic              unbounded;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic ptr_reset;
      logic ptr_step;
      logic full_span;
      logic clear_wr;
      logic ins_rd;
      logic ins_wr;
      logic init_wr;
      logic relax_issue;
      logic check_issue;
      logic scan_issue;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic ins_ok;
      logic edge_present;
      logic src_ok;
      logic n_is_one;
      logic v_last;
      logic u_last;
      logic v_max;
      logic u_max;
      logic round_last;
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_READ,
      ST_INS_WRITE,
      ST_QUERY,
      ST_INIT,
      ST_RELAX,
      ST_CHECK,
      ST_CHECK_END,
      ST_SCAN,
      ST_SCAN_END,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/longest_path_bellman_ford_core.sv */
// Top level of the longest-path core: controller, datapath and checks.
// Insert: busy through the read and write states after the transfer, with no result; a new
// request is taken only once the core is idle again. Query: the result strobe follows the
// init, relax, check and scan walks (one adjacency-memory read per cycle in the relaxation
// walk); a source out of range skips the walks. The receiver cannot stall the result.
// Reset: a clearing pass over every adjacency-memory entry empties it while busy stays
// high; the register is written at any time.
`default_nettype none

module longest_path_bellman_ford_core
   import lpbf_pkg::*;
#(
   parameter int MAX_VERTICES = 64
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_item,
   output rsp_type               rsp_item,
   output logic                  rsp_strobe,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   // The controller walks the states of an operation and issues one command
   // word per cycle; the datapath answers with a status word.
   cmd_type    cmd;
   status_type status;

   lpbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // The datapath holds the adjacency and distance memories, the walk
   // counters and the one-stage compare that relaxes, checks and scans.
   lpbf_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   // A transfer always makes the core busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after an input transfer");

   // Results never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high in two consecutive cycles");

   // An unbounded answer carries no gain.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.unbounded) |-> (rsp_item.best_gain == '0))
      else $error("unbounded result with non-zero gain");

   // A result only follows a cycle in which the core was working.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe while the core was idle");

endmodule

`default_nettype wire

/* rtl/core/lpbf_ctrl.sv */
// Sequencing state machine of the longest-path core.
`default_nettype none

module lpbf_ctrl
   import lpbf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       operation,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr  = 1'b1;
            cmd.full_span = 1'b1;
            cmd.ptr_step  = 1'b1;
            if (status.u_max && status.v_max) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.ptr_reset = 1'b1;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = (operation == OP_QUERY) ? ST_QUERY : ST_INS_READ;
            end
         end
         ST_INS_READ: begin
            cmd.ins_rd = 1'b1;
            state_in   = ST_INS_WRITE;
         end
         ST_INS_WRITE: begin
            // Edges are never overwritten: only a fresh, legal edge is stored.
            cmd.ins_wr = status.ins_ok && !status.edge_present;
            state_in   = ST_IDLE;
         end
         ST_QUERY: begin
            state_in = status.src_ok ? ST_INIT : ST_REPLY;
         end
         ST_INIT: begin
            cmd.init_wr  = 1'b1;
            cmd.ptr_step = 1'b1;
            if (status.v_last) begin
               cmd.ptr_reset = 1'b1;
               state_in      = status.n_is_one ? ST_CHECK : ST_RELAX;
            end
         end
         ST_RELAX: begin
            cmd.relax_issue = 1'b1;
            cmd.ptr_step    = 1'b1;
            if (status.v_last && status.u_last && status.round_last) begin
               cmd.ptr_reset = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check_issue = 1'b1;
            cmd.ptr_step    = 1'b1;
            if (status.v_last && status.u_last) begin
               cmd.ptr_reset = 1'b1;
               state_in      = ST_CHECK_END;
            end
         end
         ST_CHECK_END: begin
            cmd.ptr_reset = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.ptr_step   = 1'b1;
            if (status.v_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/lpbf_datapath.sv */
// Datapath of the longest-path core: memories, walk counters and relaxation.
`default_nettype none

module lpbf_datapath
   import lpbf_pkg::*;
#(
   parameter int MAX_VERTICES = 64
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_item,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata,
   input  wire cmd_type          cmd,
   output status_type            status,
   output rsp_type               rsp_item,
   output logic                  rsp_strobe
);

   localparam int VW         = $clog2(MAX_VERTICES);
   localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int NW         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int EDGE_DEPTH = 1 << (2 * VW);
   localparam int DIST_DEPTH = 1 << VW;

   // Configuration and the clamped vertex count.
   logic [CFG_W-1:0] cfg_ff;
   logic [CFG_W-1:0] cfg_in;
   logic [NW-1:0]    count;
   logic [NW-1:0]    count_m1;

   always_comb begin
      cfg_in = csr_we ? csr_wdata : cfg_ff;
      if (cfg_ff == '0) begin
         count = NW'(1);
      end else if (NW'(cfg_ff) > NW'(MAX_VERTICES)) begin
         count = NW'(MAX_VERTICES);
      end else begin
         count = NW'(cfg_ff);
      end
      count_m1 = count - NW'(1);
   end

   // Latched request.
   req_type req_ff;
   req_type req_in;
   logic [NW-1:0] from_ext, to_ext, src_ext;
   logic [VW-1:0] from_idx, to_idx, src_idx;

   always_comb begin
      req_in   = cmd.latch ? req_item : req_ff;
      from_ext = NW'(req_ff.edge_from);
      to_ext   = NW'(req_ff.edge_to);
      src_ext  = NW'(req_ff.source_vertex);
      from_idx = from_ext[VW-1:0];
      to_idx   = to_ext[VW-1:0];
      src_idx  = src_ext[VW-1:0];
   end

   // Walk counters: v is the inner index, u the outer one, round the pass number.
   logic [VW-1:0] u_ff, v_ff, round_ff;
   logic [VW-1:0] u_in, v_in, round_in;
   logic          v_wrap, u_wrap;

   always_comb begin
      u_in     = u_ff;
      v_in     = v_ff;
      round_in = round_ff;
      v_wrap   = cmd.full_span ? status.v_max : status.v_last;
      u_wrap   = cmd.full_span ? status.u_max : status.u_last;
      if (cmd.ptr_reset) begin
         u_in     = '0;
         v_in     = '0;
         round_in = VW'(1);
      end else if (cmd.ptr_step) begin
         if (v_wrap) begin
            v_in = '0;
            if (u_wrap) begin
               u_in     = '0;
               round_in = round_ff + VW'(1);
            end else begin
               u_in = u_ff + VW'(1);
            end
         end else begin
            v_in = v_ff + VW'(1);
         end
      end
   end

   // Edge memory: presence bit above the weight.
   logic [WEIGHT_W:0]     edge_mem [EDGE_DEPTH];
   logic [WEIGHT_W:0]     edge_rd_ff;
   logic                  edge_we;
   logic [2*VW-1:0]       edge_wa, edge_ra;
   logic [WEIGHT_W:0]     edge_wd;

   always_comb begin
      edge_we = cmd.clear_wr || cmd.ins_wr;
      edge_wa = cmd.ins_wr ? {from_idx, to_idx} : {u_ff, v_ff};
      edge_wd = cmd.ins_wr ? {1'b1, req_ff.edge_weight} : '0;
      edge_ra = cmd.ins_rd ? {from_idx, to_idx} : {u_ff, v_ff};
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   // Distance memory: reached bit above the distance, two read ports with
   // bypass of a write landing in the same cycle.
   logic [DIST_W:0] dist_mem [DIST_DEPTH];
   logic [DIST_W:0] dist_a_ff, dist_b_ff;
   logic            dist_we;
   logic [VW-1:0]   dist_wa;
   logic [DIST_W:0] dist_wd;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      dist_a_ff <= (dist_we && dist_wa == u_ff) ? dist_wd : dist_mem[u_ff];
      dist_b_ff <= (dist_we && dist_wa == v_ff) ? dist_wd : dist_mem[v_ff];
   end

   // Compare stage.
   logic                       s1_relax_ff, s1_check_ff, s1_scan_ff;
   logic                       s1_relax_in, s1_check_in, s1_scan_in;
   logic [VW-1:0]              s1_v_ff;
   logic [VW-1:0]              s1_v_in;
   logic signed [DIST_W-1:0]   du, dv, cand;
   logic signed [WEIGHT_W-1:0] wgt;
   logic [DIST_W:0]            sum_w;
   logic                       hit;

   always_comb begin
      s1_relax_in = cmd.relax_issue;
      s1_check_in = cmd.check_issue;
      s1_scan_in  = cmd.scan_issue;
      s1_v_in     = v_ff;
      du    = $signed(dist_a_ff[DIST_W-1:0]);
      dv    = $signed(dist_b_ff[DIST_W-1:0]);
      wgt   = $signed(edge_rd_ff[WEIGHT_W-1:0]);
      sum_w = {du[DIST_W-1], du} + {{(DIST_W + 1 - WEIGHT_W){wgt[WEIGHT_W-1]}}, wgt};
      if (sum_w[DIST_W] != sum_w[DIST_W-1]) begin
         cand = sum_w[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         cand = $signed(sum_w[DIST_W-1:0]);
      end
      hit = edge_rd_ff[WEIGHT_W] && dist_a_ff[DIST_W] && (!dist_b_ff[DIST_W] || dv < cand);
      dist_we = cmd.init_wr || (s1_relax_ff && hit);
      dist_wa = cmd.init_wr ? v_ff : s1_v_ff;
      dist_wd = cmd.init_wr ? {(v_ff == src_idx), DIST_W'(0)} : {1'b1, cand};
   end

   // Query outcome and result register.
   logic                     any_ff, any_in;
   logic signed [DIST_W-1:0] best_ff, best_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_comb begin
      any_in  = any_ff;
      best_in = best_ff;
      if (cmd.latch) begin
         any_in  = 1'b0;
         best_in = '0;
      end else begin
         if (s1_check_ff && hit) begin
            any_in = 1'b1;
         end
         if (s1_scan_ff && dist_b_ff[DIST_W] && dv > best_ff) begin
            best_in = dv;
         end
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = cmd.reply;
      if (cmd.reply) begin
         rsp_in.result_source = req_ff.source_vertex;
         rsp_in.best_gain     = any_ff ? '0 : best_ff[GAIN_W-1:0];
         rsp_in.unbounded     = any_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= NUM_VERTICES_RESET;
         u_ff         <= '0;
         v_ff         <= '0;
         round_ff     <= VW'(1);
         s1_relax_ff  <= 1'b0;
         s1_check_ff  <= 1'b0;
         s1_scan_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         u_ff         <= u_in;
         v_ff         <= v_in;
         round_ff     <= round_in;
         s1_relax_ff  <= s1_relax_in;
         s1_check_ff  <= s1_check_in;
         s1_scan_ff   <= s1_scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      s1_v_ff <= s1_v_in;
      any_ff  <= any_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      status.ins_ok       = (from_ext < count) && (to_ext < count) && (from_idx != to_idx);
      status.edge_present = edge_rd_ff[WEIGHT_W];
      status.src_ok       = src_ext < count;
      status.n_is_one     = count == NW'(1);
      status.v_last       = NW'(v_ff) == count_m1;
      status.u_last       = NW'(u_ff) == count_m1;
      status.v_max        = v_ff == '1;
      status.u_max        = u_ff == '1;
      status.round_last   = NW'(round_ff) == count_m1;
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = rsp_valid_ff;

endmodule

`default_nettype wire
